// ===== rtl/v3a_pkg.sv =====
// Package for the three-component vector ALU: widths, opcodes, payload types
// and saturation helpers. Used by every module of the block; depends on nothing.
package v3a_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int TOL_W      = 17;
  localparam int OP_W       = 4;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int SQRT_STEPS = WORD_W;
  localparam int NUM_W      = WORD_W + FRAC_W;
  localparam int COS_STEPS  = FRAC_W;
  localparam int LAT        = 5 + SQRT_STEPS + NUM_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_NEG   = 4'd2;
  localparam logic [OP_W-1:0] OP_DOT   = 4'd3;
  localparam logic [OP_W-1:0] OP_CROSS = 4'd4;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd6;
  localparam logic [OP_W-1:0] OP_MAG   = 4'd7;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd8;
  localparam logic [OP_W-1:0] OP_COS   = 4'd9;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] ONE_Q =
    {{(WORD_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [WORD_W-1:0] a_x;
    logic signed [WORD_W-1:0] a_y;
    logic signed [WORD_W-1:0] a_z;
    logic signed [WORD_W-1:0] b_x;
    logic signed [WORD_W-1:0] b_y;
    logic signed [WORD_W-1:0] b_z;
    logic signed [WORD_W-1:0] scalar_in;
  } v3a_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] r_x;
    logic signed [WORD_W-1:0] r_y;
    logic signed [WORD_W-1:0] r_z;
    logic signed [WORD_W-1:0] scalar_out;
    logic                     error_flag;
  } v3a_out_t;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] r;
    logic [WORD_W-1:0]      sc;
    logic                   err;
  } res_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] pab;
    logic signed [PROD_W-1:0] paa;
    logic signed [PROD_W-1:0] pbb;
    logic signed [PROD_W-1:0] pjk;
    logic signed [PROD_W-1:0] pkj;
    logic signed [PROD_W-1:0] pas;
  } lane_prod_t;

  typedef struct packed {
    logic [OP_W-1:0]        opcode;
    res_t                   early;
    logic [2:0][WORD_W-1:0] a;
    logic [WORD_W-1:0]      s;
    logic                   dneg;
    logic [PROD_W-1:0]      ad;
  } side1_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    res_t            early;
    logic [2:0]      aneg;
    logic [2:0]      azero;
    logic            sneg;
    logic            szero;
    logic            dneg;
    logic            cos_zero;
  } side2_t;

  // Returns {overflow, word} for a wide signed value clamped to the word range.
  function automatic logic [WORD_W:0] sat_word(input logic signed [DOT_W-1:0] x);
    logic [WORD_W:0] r;
    if (x > WORD_MAX) begin
      r = {1'b1, WORD_MAX};
    end else if (x < WORD_MIN) begin
      r = {1'b1, WORD_MIN};
    end else begin
      r = {1'b0, x[WORD_W-1:0]};
    end
    return r;
  endfunction

  // Returns {overflow, word} for a quotient magnitude with a separate sign.
  function automatic logic [WORD_W:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
    logic [WORD_W:0] r;
    if (!neg) begin
      if (q > {{(NUM_W-WORD_W){1'b0}}, WORD_MAX}) begin
        r = {1'b1, WORD_MAX};
      end else begin
        r = {1'b0, q[WORD_W-1:0]};
      end
    end else begin
      if (q > {{(NUM_W-WORD_W){1'b0}}, WORD_MIN}) begin
        r = {1'b1, WORD_MIN};
      end else begin
        r = {1'b0, (~q[WORD_W-1:0]) + WORD_W'(1)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/v3a_lane.sv =====
// One component lane of the vector ALU: the registered products of its element.
// Depends on v3a_pkg.
module v3a_lane import v3a_pkg::*; (
  input  logic       clk_i,
  input  word_t      a_i,
  input  word_t      b_i,
  input  word_t      aj_i,
  input  word_t      bk_i,
  input  word_t      ak_i,
  input  word_t      bj_i,
  input  word_t      s_i,
  output lane_prod_t prod_o
);

  lane_prod_t prod_d, prod_q;

  always_comb begin
    prod_d.pab = a_i * b_i;
    prod_d.paa = a_i * a_i;
    prod_d.pbb = b_i * b_i;
    prod_d.pjk = aj_i * bk_i;
    prod_d.pkj = ak_i * bj_i;
    prod_d.pas = a_i * s_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/v3a_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on v3a_pkg.
module v3a_sqrt import v3a_pkg::*; (
  input  logic              clk_i,
  input  logic [PROD_W-1:0] rad_i,
  output logic [WORD_W-1:0] root_o
);

  logic [PROD_W-1:0] rem_q [SQRT_STEPS];
  logic [PROD_W-1:0] res_q [SQRT_STEPS];
  logic [PROD_W-1:0] rem_s [SQRT_STEPS];
  logic [PROD_W-1:0] res_s [SQRT_STEPS];
  logic [PROD_W-1:0] rem_d [SQRT_STEPS];
  logic [PROD_W-1:0] res_d [SQRT_STEPS];
  logic [PROD_W:0]   one_s [SQRT_STEPS];
  logic [PROD_W:0]   trial [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rem_s[k] = rad_i;
        res_s[k] = '0;
      end else begin
        rem_s[k] = rem_q[k-1];
        res_s[k] = res_q[k-1];
      end
      one_s[k] = (PROD_W+1)'(1) << (PROD_W - 2 - 2 * k);
      trial[k] = {1'b0, res_s[k]} + one_s[k];
      if ({1'b0, rem_s[k]} >= trial[k]) begin
        rem_d[k] = rem_s[k] - trial[k][PROD_W-1:0];
        res_d[k] = (res_s[k] >> 1) + one_s[k][PROD_W-1:0];
      end else begin
        rem_d[k] = rem_s[k];
        res_d[k] = res_s[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem_q[k] <= rem_d[k];
      res_q[k] <= res_d[k];
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][WORD_W-1:0];

endmodule

// ===== rtl/v3a_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a preset remainder.
// Depends on v3a_pkg only through the importing convention.
module v3a_div import v3a_pkg::*; #(
  parameter int QW = 48,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] nq_s  [QW];
  logic [DW-1:0] den_s [QW];
  logic [DW:0]   sh    [QW];
  logic [DW:0]   dif   [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] nq_d  [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_s[k] = rem_i;
        nq_s[k]  = num_i;
        den_s[k] = den_i;
      end else begin
        rem_s[k] = rem_q[k-1];
        nq_s[k]  = nq_q[k-1];
        den_s[k] = den_q[k-1];
      end
      sh[k]  = {rem_s[k], nq_s[k][QW-1]};
      dif[k] = sh[k] - {1'b0, den_s[k]};
      if (sh[k] >= {1'b0, den_s[k]}) begin
        rem_d[k] = dif[k][DW-1:0];
        nq_d[k]  = {nq_s[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = sh[k][DW-1:0];
        nq_d[k]  = {nq_s[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rem_q[k] <= rem_d[k];
      nq_q[k]  <= nq_d[k];
      den_q[k] <= den_s[k];
    end
  end

  assign quo_o = nq_q[QW-1];

endmodule

// ===== rtl/vector3_alu.sv =====
// Three-component vector ALU in signed Q16.16, fully pipelined over lanes.
// The result strobe follows a transfer through the input register, the lanes,
// merge, 32-stage square root, preparation, 48-stage divider lanes and output.
// Throughput: one item per cycle; busy is never asserted and there are no stalls.
// Reset clears the pipeline valid bits and sets the tolerance register to 7.
// Depends on v3a_pkg, v3a_lane, v3a_sqrt and v3a_div.
module vector3_alu import v3a_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  v3a_in_t          item_i,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output v3a_out_t         result_o
);

  localparam int CQ_DLY = NUM_W - COS_STEPS;

  logic             accept;
  logic [TOL_W-1:0] tol_q;
  logic [LAT-1:0]   vld_q;
  v3a_in_t          in_q, in1_q;
  word_t            av [3];
  word_t            bv [3];
  word_t            av1 [3];
  word_t            bv1 [3];
  lane_prod_t       prod [3];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= item_i;
    in1_q <= in_q;
  end

  assign av[0] = in_q.a_x;
  assign av[1] = in_q.a_y;
  assign av[2] = in_q.a_z;
  assign bv[0] = in_q.b_x;
  assign bv[1] = in_q.b_y;
  assign bv[2] = in_q.b_z;
  assign av1[0] = in1_q.a_x;
  assign av1[1] = in1_q.a_y;
  assign av1[2] = in1_q.a_z;
  assign bv1[0] = in1_q.b_x;
  assign bv1[1] = in1_q.b_y;
  assign bv1[2] = in1_q.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk_i  (clk_i),
      .a_i    (av[i]),
      .b_i    (bv[i]),
      .aj_i   (av[(i+1)%3]),
      .bk_i   (bv[(i+2)%3]),
      .ak_i   (av[(i+2)%3]),
      .bj_i   (bv[(i+1)%3]),
      .s_i    (in_q.scalar_in),
      .prod_o (prod[i])
    );
  end

  // Merge stage: product sums; add, sub, neg, dot, cross and scale results.
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] cr [3];
  logic [PROD_W-1:0]       sa_d, sb_d, sa_q, sb_q;
  logic [WORD_W:0]         sw [3];
  logic [WORD_W:0]         swd;
  side1_t                  s1_d;
  side1_t                  s1_q [SQRT_STEPS+1];

  always_comb begin
    dot  = DOT_W'(prod[0].pab) + DOT_W'(prod[1].pab) + DOT_W'(prod[2].pab);
    sa_d = prod[0].paa[PROD_W-1:0] + prod[1].paa[PROD_W-1:0] + prod[2].paa[PROD_W-1:0];
    sb_d = prod[0].pbb[PROD_W-1:0] + prod[1].pbb[PROD_W-1:0] + prod[2].pbb[PROD_W-1:0];
    swd  = sat_word(dot >>> FRAC_W);
    s1_d.opcode = in1_q.opcode;
    s1_d.early  = '0;
    for (int i = 0; i < 3; i++) begin
      cr[i] = DOT_W'(prod[i].pjk) - DOT_W'(prod[i].pkj);
      case (in1_q.opcode)
        OP_ADD:   sw[i] = sat_word(DOT_W'(av1[i]) + DOT_W'(bv1[i]));
        OP_SUB:   sw[i] = sat_word(DOT_W'(av1[i]) - DOT_W'(bv1[i]));
        OP_NEG:   sw[i] = sat_word(-DOT_W'(av1[i]));
        OP_CROSS: sw[i] = sat_word(cr[i] >>> FRAC_W);
        OP_SCALE: sw[i] = sat_word(DOT_W'(prod[i].pas) >>> FRAC_W);
        default:  sw[i] = '0;
      endcase
      s1_d.early.r[i] = sw[i][WORD_W-1:0];
      s1_d.a[i]       = av1[i];
    end
    case (in1_q.opcode)
      OP_ADD, OP_SUB, OP_NEG, OP_CROSS, OP_SCALE: begin
        s1_d.early.err = sw[0][WORD_W] | sw[1][WORD_W] | sw[2][WORD_W];
      end
      OP_DOT: begin
        s1_d.early.sc  = swd[WORD_W-1:0];
        s1_d.early.err = swd[WORD_W];
      end
      OP_DIV, OP_MAG, OP_NORM, OP_COS: begin
        s1_d.early.err = 1'b0;
      end
      default: begin
        s1_d.early.err = 1'b1;
      end
    endcase
    s1_d.s    = in1_q.scalar_in;
    s1_d.dneg = dot[DOT_W-1];
    s1_d.ad   = dot[DOT_W-1] ? PROD_W'(-dot) : dot[PROD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    s1_q[0] <= s1_d;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      s1_q[k] <= s1_q[k-1];
    end
  end

  logic [WORD_W-1:0] ma, mb;

  v3a_sqrt u_sqrt_a (
    .clk_i  (clk_i),
    .rad_i  (sa_q),
    .root_o (ma)
  );

  v3a_sqrt u_sqrt_b (
    .clk_i  (clk_i),
    .rad_i  (sb_q),
    .root_o (mb)
  );

  // Preparation stage: divisor, numerators, length product and magnitude result.
  side1_t            s1l;
  side2_t            s2_d;
  side2_t            s2_q [NUM_W+1];
  logic [WORD_W-1:0] ma_n, s_abs, den_d, den_q;
  logic [WORD_W-1:0] a_abs [3];
  logic [NUM_W-1:0]  num_d [3];
  logic [NUM_W-1:0]  num_q [3];
  logic [PROD_W-1:0] p_q, ad_q;

  always_comb begin
    s1l  = s1_q[SQRT_STEPS];
    ma_n = (WORD_W'(tol_q) >= ma) ? ONE_Q : ma;
    s_abs = s1l.s[WORD_W-1] ? (~s1l.s) + WORD_W'(1) : s1l.s;
    den_d = (s1l.opcode == OP_DIV) ? s_abs : ma_n;
    s2_d.opcode = s1l.opcode;
    s2_d.early  = s1l.early;
    if (s1l.opcode == OP_MAG) begin
      s2_d.early.sc  = ma[WORD_W-1] ? WORD_MAX : ma;
      s2_d.early.err = ma[WORD_W-1];
    end
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = s1l.a[i][WORD_W-1] ? (~s1l.a[i]) + WORD_W'(1) : s1l.a[i];
      num_d[i] = {a_abs[i], {FRAC_W{1'b0}}};
      s2_d.aneg[i]  = s1l.a[i][WORD_W-1];
      s2_d.azero[i] = (s1l.a[i] == '0);
    end
    s2_d.sneg     = s1l.s[WORD_W-1];
    s2_d.szero    = (s1l.s == '0);
    s2_d.dneg     = s1l.dneg;
    s2_d.cos_zero = (ma == '0) || (mb == '0);
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    p_q     <= ma * mb;
    ad_q    <= s1l.ad;
    s2_q[0] <= s2_d;
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= num_d[i];
    end
    for (int k = 1; k <= NUM_W; k++) begin
      s2_q[k] <= s2_q[k-1];
    end
  end

  logic [NUM_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(
      .QW (NUM_W),
      .DW (WORD_W)
    ) u_div (
      .clk_i (clk_i),
      .rem_i ('0),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo[i])
    );
  end

  logic                cos_one;
  logic [PROD_W-1:0]   cos_rem;
  logic [COS_STEPS-1:0] cq;
  logic [NUM_W-1:0]    cone_q;
  logic [COS_STEPS-1:0] cq_q [CQ_DLY];

  assign cos_one = !(ad_q < p_q);
  assign cos_rem = cos_one ? '0 : ad_q;

  v3a_div #(
    .QW (COS_STEPS),
    .DW (PROD_W)
  ) u_cos_div (
    .clk_i (clk_i),
    .rem_i (cos_rem),
    .num_i ('0),
    .den_i (p_q),
    .quo_o (cq)
  );

  always_ff @(posedge clk_i) begin
    cone_q   <= {cone_q[NUM_W-2:0], cos_one};
    cq_q[0]  <= cq;
    for (int k = 1; k < CQ_DLY; k++) begin
      cq_q[k] <= cq_q[k-1];
    end
  end

  // Final stage: quotient saturation, tolerance zeroing and cosine sign.
  side2_t            s2l;
  res_t              res_d, res_q;
  logic [WORD_W:0]   sq [3];
  logic [WORD_W-1:0] ct;

  always_comb begin
    s2l   = s2_q[NUM_W];
    res_d = s2l.early;
    ct    = cone_q[NUM_W-1] ? ONE_Q : WORD_W'(cq_q[CQ_DLY-1]);
    for (int i = 0; i < 3; i++) begin
      sq[i] = '0;
    end
    case (s2l.opcode)
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (s2l.szero) begin
            sq[i] = {1'b1, s2l.aneg[i] ? WORD_MIN : (s2l.azero[i] ? '0 : WORD_MAX)};
          end else begin
            sq[i] = sat_quo(quo[i], s2l.aneg[i] ^ s2l.sneg);
          end
          res_d.r[i] = sq[i][WORD_W-1:0];
        end
        res_d.err = sq[0][WORD_W] | sq[1][WORD_W] | sq[2][WORD_W];
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (quo[i] < NUM_W'(tol_q)) begin
            sq[i] = '0;
          end else begin
            sq[i] = sat_quo(quo[i], s2l.aneg[i]);
          end
          res_d.r[i] = sq[i][WORD_W-1:0];
        end
        res_d.err = sq[0][WORD_W] | sq[1][WORD_W] | sq[2][WORD_W];
      end
      OP_COS: begin
        if (s2l.cos_zero) begin
          res_d.sc  = WORD_MAX;
          res_d.err = 1'b1;
        end else begin
          res_d.sc  = s2l.dneg ? (~ct) + WORD_W'(1) : ct;
          res_d.err = 1'b0;
        end
      end
      default: begin
        res_d = s2l.early;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o              = vld_q[LAT-1];
  assign result_o.r_x        = res_q.r[0];
  assign result_o.r_y        = res_q.r[1];
  assign result_o.r_z        = res_q.r[2];
  assign result_o.scalar_out = res_q.sc;
  assign result_o.error_flag = res_q.err;

`ifndef SYNTH
  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without a transfer one pipeline latency earlier");

  a_bad_opcode_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(item_i.opcode, LAT) > OP_COS) |-> result_o.error_flag)
    else $error("undefined opcode did not raise the error flag");

  a_scalar_ops_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(item_i.opcode, LAT) == OP_DOT || $past(item_i.opcode, LAT) == OP_MAG
      || $past(item_i.opcode, LAT) == OP_COS)
    |-> result_o.r_x == '0 && result_o.r_y == '0 && result_o.r_z == '0)
    else $error("scalar operation produced a nonzero result vector");

  a_cos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(item_i.opcode, LAT) == OP_COS && !result_o.error_flag
    |-> result_o.scalar_out <= $signed(ONE_Q) && result_o.scalar_out >= -$signed(ONE_Q))
    else $error("cosine result outside of minus one to one");
`endif

endmodule
